@@ sv/boolean_expression_tokenizer_assert.svh @@
// Assertion macros for the boolean expression tokenizer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BOOLEAN_EXPRESSION_TOKENIZER_ASSERT_SVH
`define BOOLEAN_EXPRESSION_TOKENIZER_ASSERT_SVH

// Property that must hold in the same cycle.
`define BET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean expression tokenizer package
// Token kinds, lexer phase codes, character constants and the result buffer
// type shared by the tokenizer logic.
// ----------------------------------------------------------------------------
package bet_pkg;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_CONST  = 4'd0,
    KIND_AND    = 4'd1,
    KIND_OR     = 4'd2,
    KIND_NOT    = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_IMPL   = 4'd6,
    KIND_EQUIV  = 4'd7,
    KIND_IDENT  = 4'd8,
    KIND_END    = 4'd9,
    KIND_ERROR  = 4'd10
  } token_kind_e;

  // Lexer phase codes.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_NUM   = 3'd1;
  localparam logic [2:0] PH_IDENT = 3'd2;
  localparam logic [2:0] PH_EQ    = 3'd3;
  localparam logic [2:0] PH_LT    = 3'd4;
  localparam logic [2:0] PH_LTEQ  = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_AMP    = 8'h26;  // '&'
  localparam logic [7:0] CH_BAR    = 8'h7C;  // '|'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned NumWidth   = 31;
  localparam int unsigned MaxResults = 3;
  localparam logic [NumWidth-1:0] NumMax = {NumWidth{1'b1}};

  // One result item.
  typedef struct packed {
    token_kind_e         kind;
    logic [NumWidth-1:0] num;
    logic [7:0]          ch;
    logic                iend;
  } res_entry_t;

  // The results that one input item causes, in order.
  typedef struct packed {
    logic [1:0]                       cnt;
    res_entry_t [MaxResults-1:0]      ent;
  } res_buf_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Append one result to the buffer; a full buffer drops it.
  function automatic res_buf_t push(res_buf_t b, token_kind_e kind,
                                    logic [NumWidth-1:0] num, logic [7:0] ch,
                                    logic iend);
    res_buf_t r;
    r = b;
    if (b.cnt < 2'(MaxResults)) begin
      r.ent[b.cnt].kind = kind;
      r.ent[b.cnt].num  = num;
      r.ent[b.cnt].ch   = ch;
      r.ent[b.cnt].iend = iend;
      r.cnt             = b.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

@@ sv/boolean_expression_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean expression tokenizer
// Streaming lexer: one character in, up to three tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on the input channel (in_valid_i / in_ready_o) with
//   string_end_i set on the final character. Tokens leave on the result
//   channel (out_valid_o / out_ready_i); run_last_o marks the last token that
//   a character caused. Identifiers come out one character per token, each
//   delayed by one input, with ident_end_o on the final character.
//   The lexer state is updated in the cycle of the input transfer and the
//   tokens are written into a three-entry result register, so the first
//   token is visible in the cycle after its character is taken.
//   A character that causes at most one token leaves room for the next one
//   in the following cycle when the receiver is ready, so the throughput is
//   then one character per cycle; a character that causes more tokens holds
//   the input while the result register drains, one token per ready cycle.
//   Characters causing no token (whitespace, digits after the first of a
//   constant, the first letter of an identifier) leave the register empty.
//   Reset clears the lexer to idle and empties the result register.
//   When the receiver stalls, the result register holds its tokens and the
//   input is taken again only once the last token of the previous character
//   is being transferred.
// ----------------------------------------------------------------------------
module boolean_expression_tokenizer
  import bet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                string_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          token_kind_o,
  output logic [NumWidth-1:0] number_value_o,
  output logic [7:0]          ident_char_o,
  output logic                ident_end_o,
  output logic                run_last_o
);

`include "boolean_expression_tokenizer_assert.svh"

  logic [2:0]          phase_q, phase_d;
  logic [NumWidth-1:0] accum_q, accum_d;
  logic [7:0]          held_q, held_d;
  logic [1:0]          cnt_q, cnt_d;
  res_entry_t [MaxResults-1:0] ent_q, ent_d;
  res_buf_t            new_res;
  logic                in_fire, out_fire;
  logic [NumWidth+3:0] num_next;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  // Next constant value: accum * 10 + digit, kept wide for the overflow check.
  assign num_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                    + {{(NumWidth){1'b0}}, 4'(char_code_i - CH_ZERO)};

  // Lexer step: phase update and the list of tokens for this character.
  always_comb begin
    logic err;
    logic fresh;
    res_buf_t r;
    err      = 1'b0;
    fresh    = 1'b1;
    r        = '0;
    phase_d  = phase_q;
    accum_d  = accum_q;
    held_d   = held_q;

    if (phase_q == PH_SKIP) begin
      // After an error everything is ignored up to the final character.
      fresh = 1'b0;
      if (string_end_i) begin
        phase_d = PH_IDLE;
        accum_d = '0;
        held_d  = '0;
      end
    end else begin
      unique case (phase_q)
        PH_NUM: begin
          if (is_digit(char_code_i)) begin
            if (num_next > {4'b0000, NumMax}) begin
              err = 1'b1;
            end else begin
              accum_d = num_next[NumWidth-1:0];
            end
            fresh = 1'b0;
          end else begin
            r       = push(r, KIND_CONST, accum_q, 8'h00, 1'b0);
            phase_d = PH_IDLE;
            accum_d = '0;
          end
        end
        PH_IDENT: begin
          if (is_alpha(char_code_i) || is_digit(char_code_i)) begin
            r      = push(r, KIND_IDENT, '0, held_q, 1'b0);
            held_d = char_code_i;
            fresh  = 1'b0;
          end else begin
            r       = push(r, KIND_IDENT, '0, held_q, 1'b1);
            phase_d = PH_IDLE;
            held_d  = '0;
          end
        end
        PH_EQ, PH_LTEQ: begin
          fresh = 1'b0;
          if (char_code_i == CH_GT) begin
            r = push(r, (phase_q == PH_EQ) ? KIND_IMPL : KIND_EQUIV, '0, 8'h00, 1'b0);
            phase_d = PH_IDLE;
          end else begin
            err = 1'b1;
          end
        end
        PH_LT: begin
          fresh = 1'b0;
          if (char_code_i == CH_EQ) begin
            phase_d = PH_LTEQ;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      // A character that starts a new token, or a single-character token.
      if (fresh && !err) begin
        priority if (is_space(char_code_i)) begin
          phase_d = phase_d;
        end else if (is_digit(char_code_i)) begin
          phase_d = PH_NUM;
          accum_d = NumWidth'(char_code_i - CH_ZERO);
        end else if (is_alpha(char_code_i)) begin
          phase_d = PH_IDENT;
          held_d  = char_code_i;
        end else if (char_code_i == CH_AMP) begin
          r = push(r, KIND_AND, '0, 8'h00, 1'b0);
        end else if (char_code_i == CH_BAR) begin
          r = push(r, KIND_OR, '0, 8'h00, 1'b0);
        end else if (char_code_i == CH_BANG) begin
          r = push(r, KIND_NOT, '0, 8'h00, 1'b0);
        end else if (char_code_i == CH_LPAREN) begin
          r = push(r, KIND_LPAREN, '0, 8'h00, 1'b0);
        end else if (char_code_i == CH_RPAREN) begin
          r = push(r, KIND_RPAREN, '0, 8'h00, 1'b0);
        end else if (char_code_i == CH_EQ) begin
          phase_d = PH_EQ;
        end else if (char_code_i == CH_LT) begin
          phase_d = PH_LT;
        end else begin
          err = 1'b1;
        end
      end

      // Final character: flush an open token and close the expression.
      if (!err && string_end_i) begin
        if (phase_d == PH_NUM) begin
          r = push(r, KIND_CONST, accum_d, 8'h00, 1'b0);
        end else if (phase_d == PH_IDENT) begin
          r = push(r, KIND_IDENT, '0, held_d, 1'b1);
        end else if ((phase_d == PH_EQ) || (phase_d == PH_LT) || (phase_d == PH_LTEQ)) begin
          err = 1'b1;
        end
        if (!err) begin
          r = push(r, KIND_END, '0, 8'h00, 1'b0);
        end
        phase_d = PH_IDLE;
        accum_d = '0;
        held_d  = '0;
      end

      if (err) begin
        r       = push(r, KIND_ERROR, '0, 8'h00, 1'b0);
        phase_d = string_end_i ? PH_IDLE : PH_SKIP;
        accum_d = '0;
        held_d  = '0;
      end
    end
    new_res = r;
  end

  // Result register: loaded on an input transfer, shifted on an output transfer.
  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (in_fire) begin
      cnt_d = new_res.cnt;
      ent_d = new_res.ent;
    end else if (out_fire) begin
      cnt_d    = cnt_q - 2'd1;
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      accum_q <= '0;
      held_q  <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        held_q  <= held_d;
      end
    end
  end

  // Token payload.
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign token_kind_o   = ent_q[0].kind;
  assign number_value_o = ent_q[0].num;
  assign ident_char_o   = ent_q[0].ch;
  assign ident_end_o    = ent_q[0].iend;
  assign run_last_o     = (cnt_q == 2'd1);

  // Checks on the lexer and the result register.
  `BET_ASSERT(a_accum_num, (phase_q == PH_NUM) || (accum_q == '0), "stray constant value")
  `BET_ASSERT(a_held_ident, (phase_q == PH_IDENT) || (held_q == '0), "stray identifier char")
  `BET_ASSERT_NEXT(a_skip_quiet, in_fire && (phase_q == PH_SKIP), !out_valid_o, "token in skip")
  `BET_ASSERT_NEXT(a_drain, out_fire && run_last_o && !in_fire, !out_valid_o, "drain failed")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean expression tokenizer testbench
// Streams expressions, one character per transfer, into the tokenizer and
// checks every token against a cycle-free lexer model kept alongside. The
// stimulus starts with a short directed set covering every operator, the
// number limit, broken operators and unknown characters, then moves on to
// random expressions. Most are well formed and some carry faults. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import bet_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldAt     = 40;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned AccWidth   = NumWidth + 4;

  // One character waiting to be offered, with the idle cycles in front of it.
  typedef struct {
    logic [7:0]  code;
    logic        last;
    int unsigned gap;
  } send_item_t;

  // One token as the tokenizer should deliver it.
  typedef struct {
    token_kind_e         kind;
    logic [NumWidth-1:0] num;
    logic [7:0]          ch;
    logic                iend;
    logic                rlast;
  } token_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [7:0]          char_code    = 8'd0;
  logic                string_end   = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [3:0]          token_kind;
  logic [NumWidth-1:0] number_value;
  logic [7:0]          ident_char;
  logic                ident_end;
  logic                run_last;

  send_item_t          chars_to_send[$];
  logic [7:0]          expr_chars[$];
  token_t              tokens_due[$];
  token_t              lex_out[$];
  send_item_t          next_char;
  token_t              due_token;
  logic                send_burst;
  int unsigned         send_idle;
  int unsigned         stall_left;
  int unsigned         recv_wait;
  int unsigned         tokens_seen  = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         fail_count   = 0;
  int unsigned         expr_tokens;
  logic                expr_clean;

  // Lexer model state.
  logic [2:0]          lx_phase     = PH_IDLE;
  logic [NumWidth-1:0] lx_accum     = '0;
  logic [7:0]          lx_held      = 8'd0;

  boolean_expression_tokenizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .string_end_i   (string_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .number_value_o (number_value),
    .ident_char_o   (ident_char),
    .ident_end_o    (ident_end),
    .run_last_o     (run_last)
  );

  // Character classes.
  function automatic logic is_numeral(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic token_t make_token(token_kind_e k, logic [NumWidth-1:0] n,
                                        logic [7:0] ch, logic e);
    token_t t;
    t.kind  = k;
    t.num   = n;
    t.ch    = ch;
    t.iend  = e;
    t.rlast = 1'b0;
    return t;
  endfunction

  // Append a token to those that the current character yields.
  task automatic emit_token(input token_t t);
    lex_out.insert(lex_out.size(), t);
  endtask

  task automatic lexer_clear();
    lx_phase = PH_IDLE;
    lx_accum = '0;
    lx_held  = 8'd0;
  endtask

  // Advance the lexer model by one character and queue the tokens it yields.
  task automatic lex_char(input logic [7:0] c, input logic fin);
    token_t              t;
    logic                fault;
    logic                fresh;
    logic [AccWidth-1:0] wide;
    fault = 1'b0;
    fresh = 1'b1;
    lex_out.delete();
    if (lx_phase == PH_SKIP) begin
      // After a fault everything is dropped up to the final character.
      if (fin) lexer_clear();
    end else begin
      // Finish or extend whatever token is open.
      case (lx_phase)
        PH_NUM: begin
          if (is_numeral(c)) begin
            wide = {4'd0, lx_accum} * 10 + (c - CH_ZERO);
            if (wide > {4'd0, NumMax}) fault = 1'b1;
            else lx_accum = wide[NumWidth-1:0];
            fresh = 1'b0;
          end else begin
            emit_token(make_token(KIND_CONST, lx_accum, 8'd0, 1'b0));
            lx_phase = PH_IDLE;
            lx_accum = '0;
          end
        end
        PH_IDENT: begin
          if (is_letter(c) || is_numeral(c)) begin
            emit_token(make_token(KIND_IDENT, '0, lx_held, 1'b0));
            lx_held = c;
            fresh   = 1'b0;
          end else begin
            emit_token(make_token(KIND_IDENT, '0, lx_held, 1'b1));
            lx_phase = PH_IDLE;
            lx_held  = 8'd0;
          end
        end
        PH_EQ: begin
          fresh = 1'b0;
          if (c == CH_GT) begin
            emit_token(make_token(KIND_IMPL, '0, 8'd0, 1'b0));
            lx_phase = PH_IDLE;
          end else begin
            fault = 1'b1;
          end
        end
        PH_LT: begin
          fresh = 1'b0;
          if (c == CH_EQ) lx_phase = PH_LTEQ;
          else fault = 1'b1;
        end
        PH_LTEQ: begin
          fresh = 1'b0;
          if (c == CH_GT) begin
            emit_token(make_token(KIND_EQUIV, '0, 8'd0, 1'b0));
            lx_phase = PH_IDLE;
          end else begin
            fault = 1'b1;
          end
        end
        default: lx_phase = PH_IDLE;
      endcase

      // Lex the character on its own.
      if (fresh && !fault && !is_blank(c)) begin
        if (is_numeral(c)) begin
          lx_phase = PH_NUM;
          lx_accum = NumWidth'(c - CH_ZERO);
        end else if (is_letter(c)) begin
          lx_phase = PH_IDENT;
          lx_held  = c;
        end else begin
          case (c)
            CH_AMP:    emit_token(make_token(KIND_AND, '0, 8'd0, 1'b0));
            CH_BAR:    emit_token(make_token(KIND_OR, '0, 8'd0, 1'b0));
            CH_BANG:   emit_token(make_token(KIND_NOT, '0, 8'd0, 1'b0));
            CH_LPAREN: emit_token(make_token(KIND_LPAREN, '0, 8'd0, 1'b0));
            CH_RPAREN: emit_token(make_token(KIND_RPAREN, '0, 8'd0, 1'b0));
            CH_EQ:     lx_phase = PH_EQ;
            CH_LT:     lx_phase = PH_LT;
            default:   fault = 1'b1;
          endcase
        end
      end

      // The final character flushes an open token, or faults on a pending one.
      if (!fault && fin) begin
        if (lx_phase == PH_NUM) begin
          emit_token(make_token(KIND_CONST, lx_accum, 8'd0, 1'b0));
        end else if (lx_phase == PH_IDENT) begin
          emit_token(make_token(KIND_IDENT, '0, lx_held, 1'b1));
        end else if ((lx_phase == PH_EQ) || (lx_phase == PH_LT) || (lx_phase == PH_LTEQ)) begin
          fault = 1'b1;
        end
        if (!fault) emit_token(make_token(KIND_END, '0, 8'd0, 1'b0));
        lexer_clear();
      end

      if (fault) begin
        emit_token(make_token(KIND_ERROR, '0, 8'd0, 1'b0));
        lexer_clear();
        if (!fin) lx_phase = PH_SKIP;
      end

      foreach (lex_out[i]) begin
        t       = lex_out[i];
        t.rlast = (i == lex_out.size() - 1);
        tokens_due.insert(tokens_due.size(), t);
      end
    end
  endtask

  // Expression building.
  task automatic add_char(input logic [7:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(8'(s[i]));
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'(CH_UC_A + $urandom_range(0, 25));
    return 8'(CH_LC_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_blank();
    int unsigned v;
    v = $urandom_range(8, 13);
    if (v == 8) return CH_SPACE;
    return 8'(v);
  endfunction

  // Move the expression under construction onto the send queue, marking its
  // final character.
  task automatic flush_expr();
    send_item_t s;
    foreach (expr_chars[i]) begin
      s.code = expr_chars[i];
      s.last = (i == expr_chars.size() - 1);
      s.gap  = send_burst ? 0 : $urandom_range(0, 14);
      chars_to_send.insert(chars_to_send.size(), s);
    end
    expr_chars.delete();
  endtask

  // Append one random token; broken operators and unknown characters only when allowed.
  task automatic add_token(input logic allow_fault);
    int unsigned r;
    int unsigned n;
    r = allow_fault ? $urandom_range(0, 99) : $urandom_range(0, 84);
    if (r < 22) begin
      // Constants: mostly short, some at ten digits near the limit.
      n = ($urandom_range(0, 6) == 0) ? 10 : $urandom_range(1, 4);
      if ((n == 10) && ($urandom_range(0, 2) == 0)) begin
        add_text("2147483647");
      end else begin
        add_char((n == 10) ? 8'(CH_ZERO + $urandom_range(1, 2))
                           : 8'(CH_ZERO + $urandom_range(0, 9)));
        repeat (n - 1) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end else if (r < 44) begin
      add_char(rand_letter());
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 2) == 0) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
        else add_char(rand_letter());
      end
    end else if (r < 70) begin
      case ($urandom_range(0, 6))
        0:       add_text("&");
        1:       add_text("|");
        2:       add_text("!");
        3:       add_text("(");
        4:       add_text(")");
        5:       add_text("=>");
        default: add_text("<=>");
      endcase
    end else if (r < 85) begin
      repeat ($urandom_range(1, 2)) add_char(rand_blank());
    end else if (r < 94) begin
      // Broken operator, followed by an arbitrary harmless character.
      case ($urandom_range(0, 2))
        0:       add_text("=");
        1:       add_text("<");
        default: add_text("<=");
      endcase
      if ($urandom_range(0, 1) == 0) add_char(rand_blank());
      else add_char(rand_letter());
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and end of run.
  initial begin
    // Directed: every operator, an identifier closed by a bracket and a
    // constant closed by an operator.
    send_burst = 1'b0;
    add_text("(a9)&!|0=><=>");
    flush_expr();
    // One past the largest constant.
    add_text("2147483648");
    flush_expr();
    // Whitespace breaking an operator, then the top code ignored while skipping.
    add_text("= ");
    add_char(8'hFF);
    flush_expr();
    // The bottom code as an unknown final character.
    add_char(8'h00);
    flush_expr();
    // Operator left pending on the final character.
    add_text("<=");
    flush_expr();

    // Random expressions, three in four of them free of broken operators and unknown characters.
    while (chars_to_send.size() < 220) begin
      send_burst  = ($urandom_range(0, 5) == 0);
      expr_clean  = ($urandom_range(0, 3) != 0);
      expr_tokens = $urandom_range(1, 10);
      repeat (expr_tokens) add_token(!expr_clean);
      flush_expr();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while ((chars_to_send.size() != 0) || in_valid || (tokens_due.size() != 0));
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // Driver: offers the queued characters, each after its own idle gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      char_code  <= 8'd0;
      string_end <= 1'b0;
      send_idle  <= 0;
    end else begin
      if (in_valid && in_ready) lex_char(char_code, string_end);
      if (!in_valid || in_ready) begin
        if ((chars_to_send.size() != 0) && (send_idle >= chars_to_send[0].gap)) begin
          next_char  = chars_to_send.pop_front();
          char_code  <= next_char.code;
          string_end <= next_char.last;
          in_valid   <= 1'b1;
          send_idle  <= 0;
        end else begin
          in_valid  <= 1'b0;
          send_idle <= send_idle + 1;
        end
      end
    end
  end

  // Monitor: checks each token transfer and paces the receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          $error("unexpected token: kind %0d", token_kind);
          fail_count++;
        end else begin
          due_token = tokens_due.pop_front();
          if (token_kind != due_token.kind) begin
            $error("token_kind: expected %0d, got %0d", due_token.kind, token_kind);
            fail_count++;
          end
          if (number_value != due_token.num) begin
            $error("number_value: expected %0d, got %0d", due_token.num, number_value);
            fail_count++;
          end
          if (ident_char != due_token.ch) begin
            $error("ident_char: expected %0h, got %0h", due_token.ch, ident_char);
            fail_count++;
          end
          if (ident_end != due_token.iend) begin
            $error("ident_end: expected %0d, got %0d", due_token.iend, ident_end);
            fail_count++;
          end
          if (run_last != due_token.rlast) begin
            $error("run_last: expected %0d, got %0d", due_token.rlast, run_last);
            fail_count++;
          end
        end
        tokens_seen++;
        // One long hold-off so the tokenizer backs up onto its input, and
        // stretches without any stall now and then.
        if (tokens_seen == HoldAt) recv_wait = HoldLen;
        else if ((tokens_seen / 25) % 4 == 3) recv_wait = 0;
        else recv_wait = $urandom_range(0, 14);
        if (recv_wait == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left <= recv_wait;
        end
      end else if (!out_ready) begin
        if (stall_left > 1) stall_left <= stall_left - 1;
        else out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule

@@ boolean_expression_tokenizer.f @@
+incdir+sv
sv/bet_pkg.sv
sv/boolean_expression_tokenizer.sv
tb/tb_top.sv
